### sv/mbrc_pkg.sv
//------------------------------------------------------------------------------
// mbrc_pkg
// Shared widths, codes and control types of the Modbus RTU reply checker.
//------------------------------------------------------------------------------
`default_nettype none

package mbrc_pkg;

   localparam int BYTE_W        = 8;
   localparam int WORD_W        = 16;
   localparam int STAT_W        = 3;
   localparam int IDX_W         = 3;
   localparam int MAX_FRAME_DEF = 256;
   localparam int MAX_REGS_DEF  = 8;
   localparam int EMIT_CAP      = 8;

   localparam logic [WORD_W-1:0] CRC_INIT = 16'hFFFF;
   localparam logic [WORD_W-1:0] CRC_POLY = 16'hA001;

   localparam logic [BYTE_W-1:0] FUNC_READ      = 8'h03;
   localparam logic [BYTE_W-1:0] FUNC_WRITE     = 8'h06;
   localparam logic [BYTE_W-1:0] FUNC_READ_EXC  = 8'h83;
   localparam logic [BYTE_W-1:0] FUNC_WRITE_EXC = 8'h86;

   // frame offsets of the header bytes and of the first data byte
   localparam int POS_ADDR = 0;
   localparam int POS_FUNC = 1;
   localparam int POS_LEN  = 2;
   localparam int POS_DATA = 3;

   typedef enum logic [STAT_W-1:0] {
      STAT_READ_OK,
      STAT_WRITE_OK,
      STAT_NO_REG,
      STAT_WRITE_FAIL,
      STAT_ADDR_ERR,
      STAT_DATA_ERR,
      STAT_UNKNOWN
   } status_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_CRC,
      FSM_STATUS,
      FSM_REGS
   } fsm_type;

   typedef struct packed {
      logic init;
      logic start;
   } crc_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } crc_stat_type;

   typedef struct packed {
      logic clear;
      logic commit;
   } store_ctrl_type;

endpackage

`default_nettype wire

### sv/mbrc_req_if.sv
//------------------------------------------------------------------------------
// mbrc_req_if
// Receive byte channel: one frame byte and its end mark per beat.
//------------------------------------------------------------------------------
`default_nettype none

interface mbrc_req_if;
   import mbrc_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;
   logic              frame_end;

   modport source (output valid, output rx_byte, output frame_end, input ready);
   modport sink   (input valid, input rx_byte, input frame_end, output ready);
endinterface

`default_nettype wire

### sv/mbrc_rsp_if.sv
//------------------------------------------------------------------------------
// mbrc_rsp_if
// Result channel: one status or register word per beat.
//------------------------------------------------------------------------------
`default_nettype none

interface mbrc_rsp_if;
   import mbrc_pkg::*;

   logic              valid;
   logic              ready;
   logic [STAT_W-1:0] status;
   logic              is_register;
   logic [IDX_W-1:0]  reg_index;
   logic [WORD_W-1:0] reg_value;
   logic              last;

   modport source (output valid, output status, output is_register, output reg_index,
                   output reg_value, output last, input ready);
   modport sink   (input valid, input status, input is_register, input reg_index,
                   input reg_value, input last, output ready);
endinterface

`default_nettype wire

### sv/mbrc_crc.sv
//------------------------------------------------------------------------------
// mbrc_crc
// Bit-serial CRC-16/MODBUS: shifts one byte in, LSB first, one bit at a time.
//------------------------------------------------------------------------------
`default_nettype none

module mbrc_crc (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire mbrc_pkg::crc_ctrl_type         ctl,
   input  wire logic [mbrc_pkg::BYTE_W-1:0]    data,
   output mbrc_pkg::crc_stat_type              stat,
   output logic      [mbrc_pkg::WORD_W-1:0]    crc
);
   import mbrc_pkg::*;

   localparam int STEP_W = $clog2(BYTE_W);

   logic [WORD_W-1:0] crc_ff, crc_in;
   logic [BYTE_W-1:0] sh_ff, sh_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              fb;
   logic              final_step;

   assign final_step = (step_ff == STEP_W'(BYTE_W - 1));
   assign fb         = crc_ff[0] ^ sh_ff[0];

   always_comb begin
      crc_in  = crc_ff;
      sh_in   = sh_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      if (ctl.init) begin
         crc_in = CRC_INIT;
      end
      if (ctl.start) begin
         sh_in   = data;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         crc_in  = (crc_ff >> 1) ^ (fb ? CRC_POLY : '0);
         sh_in   = sh_ff >> 1;
         step_in = step_ff + 1'b1;
         if (final_step) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff  <= CRC_INIT;
         step_ff <= '0;
         busy_ff <= 1'b0;
      end else begin
         crc_ff  <= crc_in;
         step_ff <= step_in;
         busy_ff <= busy_in;
      end
      sh_ff <= sh_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = busy_ff && final_step;
   assign crc       = crc_ff;

endmodule

`default_nettype wire

### sv/mbrc_store.sv
//------------------------------------------------------------------------------
// mbrc_store
// Header byte capture and register word store of the current frame.
//------------------------------------------------------------------------------
`default_nettype none

module mbrc_store #(
   parameter int CNT_W     = $clog2(mbrc_pkg::MAX_FRAME_DEF + 2),
   parameter int REG_DEPTH = mbrc_pkg::EMIT_CAP,
   parameter int RIDX_W    = (REG_DEPTH > 1) ? $clog2(REG_DEPTH) : 1
) (
   input  wire logic                           clock,
   input  wire mbrc_pkg::store_ctrl_type       ctl,
   input  wire logic      [CNT_W-1:0]          pos,
   input  wire logic      [mbrc_pkg::BYTE_W-1:0] data,
   input  wire logic      [RIDX_W-1:0]         rd_idx,
   output logic           [mbrc_pkg::BYTE_W-1:0] addr_byte,
   output logic           [mbrc_pkg::BYTE_W-1:0] func_code,
   output logic           [mbrc_pkg::BYTE_W-1:0] data_len,
   output logic           [mbrc_pkg::WORD_W-1:0] rd_word
);
   import mbrc_pkg::*;

   logic [BYTE_W-1:0] addr_ff, func_ff, len_ff;
   logic [WORD_W-1:0] store_ff [REG_DEPTH];
   logic [CNT_W-1:0]  off;
   logic [CNT_W-1:0]  wsel;
   logic              word_hit;

   assign off      = pos - CNT_W'(POS_DATA);
   assign wsel     = off >> 1;
   assign word_hit = (pos >= CNT_W'(POS_DATA)) && (wsel < CNT_W'(REG_DEPTH));

   always_ff @(posedge clock) begin
      if (ctl.clear) begin
         addr_ff <= '0;
         func_ff <= '0;
         len_ff  <= '0;
         for (int i = 0; i < REG_DEPTH; i++) begin
            store_ff[i] <= '0;
         end
      end else if (ctl.commit) begin
         if (pos == CNT_W'(POS_ADDR)) begin
            addr_ff <= data;
         end else if (pos == CNT_W'(POS_FUNC)) begin
            func_ff <= data;
         end else if (pos == CNT_W'(POS_LEN)) begin
            len_ff <= data;
         end else if (word_hit) begin
            if (!off[0]) begin
               store_ff[wsel[RIDX_W-1:0]][WORD_W-1:BYTE_W] <= data;
            end else begin
               store_ff[wsel[RIDX_W-1:0]][BYTE_W-1:0] <= data;
            end
         end
      end
   end

   assign addr_byte = addr_ff;
   assign func_code = func_ff;
   assign data_len  = len_ff;
   assign rd_word   = store_ff[rd_idx];

endmodule

`default_nettype wire

### sv/modbus_reply_frame_checker_unit.sv
//------------------------------------------------------------------------------
// modbus_reply_frame_checker_unit
// Checks a Modbus RTU reply frame and emits its status and read registers.
// A byte that enters the CRC is accepted, then shifted through it while the
// byte side is held not ready; the first two bytes of a frame and bytes past
// the length cap start no CRC run. The end mark leads to the status beat after
// the CRC, then one register beat per cycle while the result side takes them.
// Reset is synchronous: control clears and the slave address returns to 1.
//------------------------------------------------------------------------------
`default_nettype none

module modbus_reply_frame_checker_unit #(
   parameter int MAX_FRAME = mbrc_pkg::MAX_FRAME_DEF,
   parameter int MAX_REGS  = mbrc_pkg::MAX_REGS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_we,
   input  wire logic [mbrc_pkg::BYTE_W-1:0]   csr_wdata,
   mbrc_req_if.sink                           req,
   mbrc_rsp_if.source                         rsp
);
   import mbrc_pkg::*;

   localparam int CNT_W     = $clog2(MAX_FRAME + 2);
   localparam int REG_DEPTH = (MAX_REGS < EMIT_CAP) ? MAX_REGS : EMIT_CAP;
   localparam int RIDX_W    = (REG_DEPTH > 1) ? $clog2(REG_DEPTH) : 1;
   localparam int NREG_W    = $clog2(REG_DEPTH + 1);

   fsm_type            state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [WORD_W-1:0]  held_ff, held_in;
   logic               end_ff, end_in;
   logic [NREG_W-1:0]  nregs_ff, nregs_in;
   logic [RIDX_W-1:0]  emit_ff, emit_in;
   logic [BYTE_W-1:0]  slave_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   status_type         stat_ff, stat_in;
   logic               isr_ff, isr_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [WORD_W-1:0]  val_ff, val_in;
   logic               last_ff, last_in;

   crc_ctrl_type       crc_ctl;
   crc_stat_type       crc_st;
   logic [WORD_W-1:0]  crc_val;
   store_ctrl_type     st_ctl;
   logic [BYTE_W-1:0]  addr_byte, func_code, data_len;
   logic [WORD_W-1:0]  rd_word;

   logic               accept;
   logic               commit;
   logic               slot_free;
   logic [CNT_W-1:0]   pos;
   logic [BYTE_W-2:0]  half_len;
   logic [NREG_W-1:0]  nr;
   status_type         frame_stat;
   logic               last_reg;

   assign req.ready = (state_ff == FSM_IDLE);
   assign accept    = req.valid && req.ready;
   assign commit    = (count_ff >= CNT_W'(2)) && (count_ff <= CNT_W'(MAX_FRAME));
   assign pos       = count_ff - CNT_W'(2);
   assign slot_free = !rsp_valid_ff || rsp.ready;
   assign half_len  = data_len[BYTE_W-1:1];
   assign last_reg  = ((NREG_W'(emit_ff) + 1'b1) == nregs_ff);

   mbrc_crc u_crc (
      .clock (clock),
      .reset (reset),
      .ctl   (crc_ctl),
      .data  (held_ff[WORD_W-1:BYTE_W]),
      .stat  (crc_st),
      .crc   (crc_val)
   );

   mbrc_store #(
      .CNT_W     (CNT_W),
      .REG_DEPTH (REG_DEPTH),
      .RIDX_W    (RIDX_W)
   ) u_store (
      .clock     (clock),
      .ctl       (st_ctl),
      .pos       (pos),
      .data      (held_ff[WORD_W-1:BYTE_W]),
      .rd_idx    (emit_ff),
      .addr_byte (addr_byte),
      .func_code (func_code),
      .data_len  (data_len),
      .rd_word   (rd_word)
   );

   always_comb begin
      nr = ({1'b0, half_len} < BYTE_W'(REG_DEPTH)) ? NREG_W'(half_len) : NREG_W'(REG_DEPTH);
      frame_stat = STAT_UNKNOWN;
      priority if ((count_ff < CNT_W'(4)) || (count_ff > CNT_W'(MAX_FRAME))) begin
         frame_stat = STAT_DATA_ERR;
      end else if (crc_val != {held_ff[BYTE_W-1:0], held_ff[WORD_W-1:BYTE_W]}) begin
         frame_stat = STAT_DATA_ERR;
      end else if (addr_byte != slave_ff) begin
         frame_stat = STAT_ADDR_ERR;
      end else if (func_code == FUNC_READ) begin
         frame_stat = (count_ff < CNT_W'(5)) ? STAT_DATA_ERR : STAT_READ_OK;
      end else if (func_code == FUNC_WRITE) begin
         frame_stat = STAT_WRITE_OK;
      end else if (func_code == FUNC_READ_EXC) begin
         frame_stat = STAT_NO_REG;
      end else if (func_code == FUNC_WRITE_EXC) begin
         frame_stat = STAT_WRITE_FAIL;
      end else begin
         frame_stat = STAT_UNKNOWN;
      end
      if (frame_stat != STAT_READ_OK) begin
         nr = '0;
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      held_in      = held_ff;
      end_in       = end_ff;
      nregs_in     = nregs_ff;
      emit_in      = emit_ff;
      crc_ctl      = '0;
      st_ctl       = '0;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      stat_in      = stat_ff;
      isr_in       = isr_ff;
      idx_in       = idx_ff;
      val_in       = val_ff;
      last_in      = last_ff;

      unique case (state_ff)
         FSM_IDLE: begin
            if (accept) begin
               crc_ctl.init  = (count_ff == '0);
               st_ctl.clear  = (count_ff == '0);
               crc_ctl.start = commit;
               st_ctl.commit = commit;
               held_in       = (count_ff == '0) ? {BYTE_W'(0), req.rx_byte}
                                                : {held_ff[BYTE_W-1:0], req.rx_byte};
               if (count_ff <= CNT_W'(MAX_FRAME)) begin
                  count_in = count_ff + 1'b1;
               end
               end_in = req.frame_end;
               if (commit) begin
                  state_in = FSM_CRC;
               end else if (req.frame_end) begin
                  state_in = FSM_STATUS;
               end
            end
         end
         FSM_CRC: begin
            if (crc_st.done) begin
               state_in = end_ff ? FSM_STATUS : FSM_IDLE;
            end
         end
         FSM_STATUS: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               stat_in      = frame_stat;
               isr_in       = 1'b0;
               idx_in       = '0;
               val_in       = '0;
               last_in      = (nr == '0);
               count_in     = '0;
               nregs_in     = nr;
               emit_in      = '0;
               state_in     = (nr == '0) ? FSM_IDLE : FSM_REGS;
            end
         end
         FSM_REGS: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               stat_in      = STAT_READ_OK;
               isr_in       = 1'b1;
               idx_in       = IDX_W'(emit_ff);
               val_in       = rd_word;
               last_in      = last_reg;
               if (last_reg) begin
                  state_in = FSM_IDLE;
               end else begin
                  emit_in = emit_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         count_ff     <= '0;
         held_ff      <= '0;
         end_ff       <= 1'b0;
         nregs_ff     <= '0;
         emit_ff      <= '0;
         slave_ff     <= BYTE_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         held_ff      <= held_in;
         end_ff       <= end_in;
         nregs_ff     <= nregs_in;
         emit_ff      <= emit_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            slave_ff <= csr_wdata;
         end
      end
      stat_ff <= stat_in;
      isr_ff  <= isr_in;
      idx_ff  <= idx_in;
      val_ff  <= val_in;
      last_ff <= last_in;
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.status      = stat_ff;
   assign rsp.is_register = isr_ff;
   assign rsp.reg_index   = idx_ff;
   assign rsp.reg_value   = val_ff;
   assign rsp.last        = last_ff;

endmodule

`default_nettype wire

### sv/mbrc_checker.sv
//------------------------------------------------------------------------------
// mbrc_checker
// Port-level checks of the reply checker's result stream, bound to the top.
//------------------------------------------------------------------------------
`default_nettype none

module mbrc_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_ready,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic [mbrc_pkg::STAT_W-1:0]   rsp_status,
   input wire logic                          rsp_is_register,
   input wire logic [mbrc_pkg::IDX_W-1:0]    rsp_reg_index,
   input wire logic [mbrc_pkg::WORD_W-1:0]   rsp_reg_value,
   input wire logic                          rsp_last
);
   import mbrc_pkg::*;

   // no new byte while a frame still has beats to come
   a_busy_mid_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !req_ready)
      else $error("byte accepted while frame results pending");

   // register beats follow each other without gaps
   a_next_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> rsp_valid && rsp_is_register)
      else $error("gap inside frame result burst");

   a_reg_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_register |-> rsp_status == STAT_READ_OK)
      else $error("register beat with nonzero status");

   a_status_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_register |-> rsp_reg_index == '0 && rsp_reg_value == '0)
      else $error("status beat carries register data");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_reg_value) && $stable(rsp_last))
      else $error("stalled result beat changed");

endmodule

bind modbus_reply_frame_checker_unit mbrc_checker u_mbrc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req.valid),
   .req_ready       (req.ready),
   .rsp_valid       (rsp.valid),
   .rsp_ready       (rsp.ready),
   .rsp_status      (rsp.status),
   .rsp_is_register (rsp.is_register),
   .rsp_reg_index   (rsp.reg_index),
   .rsp_reg_value   (rsp.reg_value),
   .rsp_last        (rsp.last)
);

`default_nettype wire
